// ===== sv/rtdd_pkg.sv =====
// Package: shared command codes, status codes and controller/datapath interface types.
`default_nettype none
package rtdd_pkg;

    localparam int CMD_W  = 3;
    localparam int IDX_W  = 5;
    localparam int STAT_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_OPEN   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REQ    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REL    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAN  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DETECT = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_PENDING = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NONE    = 2'd2;

    // Pending-request code meaning nothing is pending
    localparam logic [IDX_W-1:0] NONE_PENDING = 5'h1F;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic clr_mode;
        logic clr_we;
        logic set_av;
        logic open_slot;
        logic held_mode;
        logic held_upd;
        logic cl_add;
        logic cl_end;
        logic k_inc;
        logic det_mode;
        logic det_init;
        logic det_check;
        logic det_add;
        logic p_step;
        logic out_load;
    } rtdd_ctl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             p_ok;
        logic             r_ok;
        logic             clear_last;
        logic             k_last;
        logic             p_last;
        logic             finish_ok;
        logic             progress;
        logic             out_busy;
    } rtdd_sts_t;

endpackage
`default_nettype wire

// ===== sv/rtdd_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module rtdd_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 360
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rd_data_reg <= mem_reg[addr];
    end

    assign rdata = rd_data_reg;
endmodule
`default_nettype wire

// ===== sv/rtdd_ctrl.sv =====
// Controller: sequences clearing, table updates, cleaning and detection passes.
`default_nettype none
module rtdd_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               m_ready,
    input  wire rtdd_pkg::rtdd_sts_t sts,
    output rtdd_pkg::rtdd_ctl_t     ctl
);
    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_HRD, ST_HUPD, ST_CLRD, ST_CLWR,
        ST_DINIT, ST_DCHK, ST_DRD, ST_DADD, ST_DNEXT, ST_FIN
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                ctl.clr_mode = 1'b1;
                ctl.clr_we   = 1'b1;
                if (sts.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (sts.cmd)
                    rtdd_pkg::CMD_SET: begin
                        ctl.set_av = 1'b1;
                        state_next = ST_FIN;
                    end
                    rtdd_pkg::CMD_OPEN: begin
                        ctl.open_slot = 1'b1;
                        state_next    = ST_FIN;
                    end
                    rtdd_pkg::CMD_REQ, rtdd_pkg::CMD_REL: begin
                        ctl.held_mode = 1'b1;
                        state_next    = (sts.p_ok && sts.r_ok) ? ST_HRD : ST_FIN;
                    end
                    rtdd_pkg::CMD_CLEAN: begin
                        state_next = sts.p_ok ? ST_CLRD : ST_FIN;
                    end
                    rtdd_pkg::CMD_DETECT: begin
                        state_next = ST_DINIT;
                    end
                    default: begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_HRD: begin
                ctl.held_mode = 1'b1;
                state_next    = ST_HUPD;
            end
            ST_HUPD: begin
                ctl.held_mode = 1'b1;
                ctl.held_upd  = 1'b1;
                state_next    = ST_FIN;
            end
            ST_CLRD: begin
                state_next = ST_CLWR;
            end
            ST_CLWR: begin
                ctl.cl_add = 1'b1;
                if (sts.k_last) begin
                    ctl.cl_end = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    ctl.k_inc  = 1'b1;
                    state_next = ST_CLRD;
                end
            end
            ST_DINIT: begin
                ctl.det_init = 1'b1;
                state_next   = ST_DCHK;
            end
            ST_DCHK: begin
                ctl.det_mode  = 1'b1;
                ctl.det_check = 1'b1;
                state_next    = sts.finish_ok ? ST_DRD : ST_DNEXT;
            end
            ST_DRD: begin
                ctl.det_mode = 1'b1;
                state_next   = ST_DADD;
            end
            ST_DADD: begin
                ctl.det_mode = 1'b1;
                ctl.det_add  = 1'b1;
                if (sts.k_last) begin
                    state_next = ST_DNEXT;
                end else begin
                    ctl.k_inc  = 1'b1;
                    state_next = ST_DRD;
                end
            end
            ST_DNEXT: begin
                ctl.p_step = 1'b1;
                if (sts.p_last && !sts.progress) state_next = ST_FIN;
                else state_next = ST_DCHK;
            end
            ST_FIN: begin
                if (!sts.out_busy || m_ready) begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/rtdd_datapath.sv =====
// Datapath: allocation tables, held-unit memory, work vector and result register.
`default_nettype none
module rtdd_datapath #(
    parameter int PROCESSES   = 18,
    parameter int RESOURCES   = 20,
    parameter int COUNT_WIDTH = 13
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [rtdd_pkg::CMD_W-1:0]        s_cmd,
    input  wire logic [rtdd_pkg::IDX_W-1:0]        s_process,
    input  wire logic [rtdd_pkg::IDX_W-1:0]        s_resource,
    input  wire logic [COUNT_WIDTH-1:0]            s_amount,
    input  wire rtdd_pkg::rtdd_ctl_t               ctl,
    output rtdd_pkg::rtdd_sts_t                    sts,
    input  wire logic                              m_ready,
    output logic                                   m_valid,
    output logic [rtdd_pkg::STAT_W-1:0]            m_status,
    output logic [$clog2(PROCESSES+1)-1:0]         m_deadlock_count,
    output logic [PROCESSES-1:0]                   m_deadlock_mask,
    output logic [COUNT_WIDTH-1:0]                 m_available_now
);
    localparam int P_W    = $clog2(PROCESSES);
    localparam int R_W    = $clog2(RESOURCES);
    localparam int DEPTH  = PROCESSES * RESOURCES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(PROCESSES+1);
    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

    function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                       input logic [COUNT_WIDTH-1:0] b);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_WIDTH] ? CMAX : s[COUNT_WIDTH-1:0];
    endfunction

    // Captured command
    logic [rtdd_pkg::CMD_W-1:0]  cmd_reg;
    logic [rtdd_pkg::IDX_W-1:0]  p_reg, r_reg;
    logic [COUNT_WIDTH-1:0]      amt_reg;
    logic [rtdd_pkg::STAT_W-1:0] stat_reg, stat_next;

    // Allocation state
    logic [COUNT_WIDTH-1:0]      avail_reg [RESOURCES];
    logic [COUNT_WIDTH-1:0]      work_reg  [RESOURCES];
    logic [PROCESSES-1:0]        occ_reg;
    logic [rtdd_pkg::IDX_W-1:0]  pend_reg  [PROCESSES];
    logic [PROCESSES-1:0]        done_reg;

    // Sequencing counters
    logic [R_W-1:0]    k_reg;
    logic [P_W-1:0]    pi_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [CNT_W-1:0]  fin_reg;
    logic              progress_reg;

    // Result register
    logic                        m_valid_reg;
    logic [rtdd_pkg::STAT_W-1:0] out_stat_reg;
    logic [CNT_W-1:0]            out_cnt_reg;
    logic [PROCESSES-1:0]        out_mask_reg;
    logic [COUNT_WIDTH-1:0]      out_av_reg;

    logic                    p_ok, r_ok, grant, pend_ok, finish_ok;
    logic [P_W-1:0]          p_idx, proc_sel;
    logic [R_W-1:0]          r_idx, res_sel;
    logic [rtdd_pkg::IDX_W-1:0] cur_pend;
    logic [ADDR_W-1:0]       mem_addr;
    logic                    mem_we;
    logic [COUNT_WIDTH-1:0]  mem_wdata, mem_rdata;

    assign p_ok  = {1'b0, p_reg} < (rtdd_pkg::IDX_W+1)'(PROCESSES);
    assign r_ok  = {1'b0, r_reg} < (rtdd_pkg::IDX_W+1)'(RESOURCES);
    assign p_idx = P_W'(p_reg);
    assign r_idx = R_W'(r_reg);

    // Held-unit memory addressing
    assign proc_sel = ctl.det_mode ? pi_reg : p_idx;
    assign res_sel  = ctl.held_mode ? r_idx : k_reg;
    assign mem_addr = ctl.clr_mode ? clr_reg
                    : ADDR_W'(ADDR_W'(proc_sel) * ADDR_W'(RESOURCES) + ADDR_W'(res_sel));

    assign grant = (avail_reg[r_idx] != '0) && (mem_rdata != CMAX);

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        if (ctl.clr_we || ctl.cl_add) begin
            mem_we = 1'b1;
        end else if (ctl.held_upd) begin
            if (cmd_reg == rtdd_pkg::CMD_REQ) begin
                mem_we    = grant;
                mem_wdata = mem_rdata + COUNT_WIDTH'(1);
            end else begin
                mem_we    = (mem_rdata != '0);
                mem_wdata = mem_rdata - COUNT_WIDTH'(1);
            end
        end
    end

    rtdd_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_held (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Finish test for the slot under scan
    assign cur_pend  = pend_reg[pi_reg];
    assign pend_ok   = {1'b0, cur_pend} < (rtdd_pkg::IDX_W+1)'(RESOURCES);
    assign finish_ok = !done_reg[pi_reg]
                     && (!occ_reg[pi_reg] || !pend_ok || (work_reg[R_W'(cur_pend)] != '0));

    // Status of the captured command
    always_comb begin
        stat_next = stat_reg;
        if (ctl.capture) begin
            stat_next = rtdd_pkg::STAT_OK;
            if (s_cmd == rtdd_pkg::CMD_REQ) stat_next = rtdd_pkg::STAT_PENDING;
            if (s_cmd == rtdd_pkg::CMD_REL) stat_next = rtdd_pkg::STAT_NONE;
        end else if (ctl.held_upd) begin
            if (cmd_reg == rtdd_pkg::CMD_REQ) begin
                stat_next = grant ? rtdd_pkg::STAT_OK : rtdd_pkg::STAT_PENDING;
            end else begin
                stat_next = (mem_rdata != '0) ? rtdd_pkg::STAT_OK : rtdd_pkg::STAT_NONE;
            end
        end
    end

    // Command capture
    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            cmd_reg <= s_cmd;
            p_reg   <= s_process;
            r_reg   <= s_resource;
            amt_reg <= s_amount;
        end
        stat_reg <= stat_next;
    end

    // Tables and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RESOURCES; i++) avail_reg[i] <= '0;
            for (int i = 0; i < PROCESSES; i++) pend_reg[i] <= rtdd_pkg::NONE_PENDING;
            occ_reg      <= '0;
            done_reg     <= '0;
            k_reg        <= '0;
            pi_reg       <= '0;
            clr_reg      <= '0;
            fin_reg      <= '0;
            progress_reg <= 1'b0;
        end else begin
            if (ctl.clr_we) clr_reg <= clr_reg + ADDR_W'(1);
            if (ctl.capture) k_reg <= '0;
            if (ctl.k_inc) k_reg <= k_reg + R_W'(1);
            if (ctl.set_av && r_ok) avail_reg[r_idx] <= amt_reg;
            if (ctl.open_slot && p_ok) occ_reg[p_idx] <= 1'b1;
            if (ctl.held_upd) begin
                if (cmd_reg == rtdd_pkg::CMD_REQ) begin
                    if (grant) begin
                        avail_reg[r_idx] <= avail_reg[r_idx] - COUNT_WIDTH'(1);
                        pend_reg[p_idx]  <= rtdd_pkg::NONE_PENDING;
                    end else begin
                        pend_reg[p_idx]  <= r_reg;
                    end
                end else if (mem_rdata != '0) begin
                    avail_reg[r_idx] <= sat_add(avail_reg[r_idx], COUNT_WIDTH'(1));
                end
            end
            if (ctl.cl_add) avail_reg[k_reg] <= sat_add(avail_reg[k_reg], mem_rdata);
            if (ctl.cl_end) begin
                occ_reg[p_idx]  <= 1'b0;
                pend_reg[p_idx] <= rtdd_pkg::NONE_PENDING;
            end
            // detection
            if (ctl.det_init) begin
                for (int i = 0; i < RESOURCES; i++) work_reg[i] <= avail_reg[i];
                done_reg     <= '0;
                pi_reg       <= '0;
                fin_reg      <= '0;
                progress_reg <= 1'b0;
            end
            if (ctl.det_check && finish_ok) begin
                done_reg[pi_reg] <= 1'b1;
                fin_reg          <= fin_reg + CNT_W'(1);
                progress_reg     <= 1'b1;
                k_reg            <= '0;
            end
            if (ctl.det_add) work_reg[k_reg] <= sat_add(work_reg[k_reg], mem_rdata);
            if (ctl.p_step) begin
                if (pi_reg == P_W'(PROCESSES-1)) begin
                    pi_reg       <= '0;
                    progress_reg <= 1'b0;
                end else begin
                    pi_reg <= pi_reg + P_W'(1);
                end
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            out_stat_reg <= stat_reg;
            out_av_reg   <= r_ok ? avail_reg[r_idx] : '0;
            if (cmd_reg == rtdd_pkg::CMD_DETECT) begin
                out_cnt_reg  <= CNT_W'(PROCESSES) - fin_reg;
                out_mask_reg <= ~done_reg;
            end else begin
                out_cnt_reg  <= '0;
                out_mask_reg <= '0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = out_stat_reg;
    assign m_deadlock_count = out_cnt_reg;
    assign m_deadlock_mask  = out_mask_reg;
    assign m_available_now  = out_av_reg;

    always_comb begin
        sts            = '0;
        sts.cmd        = cmd_reg;
        sts.p_ok       = p_ok;
        sts.r_ok       = r_ok;
        sts.clear_last = (clr_reg == ADDR_W'(DEPTH-1));
        sts.k_last     = (k_reg == R_W'(RESOURCES-1));
        sts.p_last     = (pi_reg == P_W'(PROCESSES-1));
        sts.finish_ok  = finish_ok;
        sts.progress   = progress_reg;
        sts.out_busy   = m_valid_reg;
    end
endmodule
`default_nettype wire

// ===== sv/resource_table_deadlock_detector.sv =====
// Top level: resource allocation table with deadlock detection.
`default_nettype none
// One command is handled at a time; each produces one result transfer. After
// reset the held-unit memory (PROCESSES*RESOURCES entries, 360 by default) is
// cleared one entry per cycle, and no command is taken until it is cleared.
// Request and release read the held-unit memory through its registered read
// before updating it; clean does one memory read and write per resource. Detect
// tests each slot in turn, and each finished slot reads its RESOURCES held
// counts through the single memory port; passes repeat until one finishes
// nothing.
module resource_table_deadlock_detector #(
    parameter int PROCESSES   = 18,
    parameter int RESOURCES   = 20,
    parameter int COUNT_WIDTH = 13
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [rtdd_pkg::CMD_W-1:0]    s_cmd,
    input  wire logic [rtdd_pkg::IDX_W-1:0]    s_process,
    input  wire logic [rtdd_pkg::IDX_W-1:0]    s_resource,
    input  wire logic [COUNT_WIDTH-1:0]        s_amount,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [rtdd_pkg::STAT_W-1:0]        m_status,
    output logic [$clog2(PROCESSES+1)-1:0]     m_deadlock_count,
    output logic [PROCESSES-1:0]               m_deadlock_mask,
    output logic [COUNT_WIDTH-1:0]             m_available_now
);
    rtdd_pkg::rtdd_ctl_t ctl;
    rtdd_pkg::rtdd_sts_t sts;

    rtdd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    rtdd_datapath #(
        .PROCESSES   (PROCESSES),
        .RESOURCES   (RESOURCES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_cmd            (s_cmd),
        .s_process        (s_process),
        .s_resource       (s_resource),
        .s_amount         (s_amount),
        .ctl              (ctl),
        .sts              (sts),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_status         (m_status),
        .m_deadlock_count (m_deadlock_count),
        .m_deadlock_mask  (m_deadlock_mask),
        .m_available_now  (m_available_now)
    );
endmodule
`default_nettype wire

// ===== sv/rtdd_checker.sv =====
// Port-level checker for the deadlock detector and its bind.
`default_nettype none
module rtdd_checker #(
    parameter int PROCESSES   = 18,
    parameter int COUNT_WIDTH = 13
) (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [rtdd_pkg::STAT_W-1:0]       m_status,
    input wire logic [$clog2(PROCESSES+1)-1:0]    m_deadlock_count,
    input wire logic [PROCESSES-1:0]              m_deadlock_mask,
    input wire logic [COUNT_WIDTH-1:0]            m_available_now
);
    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_deadlock_mask) && $stable(m_available_now))
        else $error("result changed while stalled");

    // Count agrees with the mask
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones(m_deadlock_mask) == 32'(m_deadlock_count))
        else $error("deadlock count does not match mask");

    // Only detect reports a mask, and detect always answers ok
    a_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != rtdd_pkg::STAT_OK |-> m_deadlock_mask == '0)
        else $error("mask reported with non-ok status");

    // Status code is one of the defined values
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == rtdd_pkg::STAT_OK || m_status == rtdd_pkg::STAT_PENDING
            || m_status == rtdd_pkg::STAT_NONE)
        else $error("undefined status code");
endmodule

bind resource_table_deadlock_detector rtdd_checker #(
    .PROCESSES   (PROCESSES),
    .COUNT_WIDTH (COUNT_WIDTH)
) u_rtdd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_deadlock_count (m_deadlock_count),
    .m_deadlock_mask  (m_deadlock_mask),
    .m_available_now  (m_available_now)
);
`default_nettype wire

// ===== tb/resource_table_deadlock_detector_checker.sv =====
// Checker: watches both channels, predicts each result and compares it.
`timescale 1ns / 1ps
module resource_table_deadlock_detector_checker #(
    parameter int PROCESSES   = 18,
    parameter int RESOURCES   = 20,
    parameter int COUNT_WIDTH = 13
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [rtdd_pkg::CMD_W-1:0]         s_cmd,
    input  logic [rtdd_pkg::IDX_W-1:0]         s_process,
    input  logic [rtdd_pkg::IDX_W-1:0]         s_resource,
    input  logic [COUNT_WIDTH-1:0]             s_amount,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [rtdd_pkg::STAT_W-1:0]        m_status,
    input  logic [$clog2(PROCESSES+1)-1:0]     m_deadlock_count,
    input  logic [PROCESSES-1:0]               m_deadlock_mask,
    input  logic [COUNT_WIDTH-1:0]             m_available_now,
    output int                                 fail_count,
    output int                                 pending_results,
    output int                                 deadlock_reports
);
    localparam int CNT_W = $clog2(PROCESSES+1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [rtdd_pkg::STAT_W-1:0] status;
        logic [CNT_W-1:0]            count;
        logic [PROCESSES-1:0]        mask;
        logic [COUNT_WIDTH-1:0]      avail;
    } table_result_t;

    // Shadow copy of the allocation table
    logic [COUNT_WIDTH-1:0]       avail_units [RESOURCES];
    logic [COUNT_WIDTH-1:0]       held [PROCESSES][RESOURCES];
    logic                         occupied [PROCESSES];
    logic [rtdd_pkg::IDX_W-1:0]   waiting_on [PROCESSES];

    table_result_t result_q[$];

    function automatic logic [COUNT_WIDTH-1:0] add_sat(logic [COUNT_WIDTH-1:0] a,
                                                       logic [COUNT_WIDTH-1:0] b);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_WIDTH] ? COUNT_MAX : s[COUNT_WIDTH-1:0];
    endfunction

    // Apply one command to the shadow table and return its result
    function automatic table_result_t apply_command(logic [rtdd_pkg::CMD_W-1:0] cmd,
                                                    logic [rtdd_pkg::IDX_W-1:0] p,
                                                    logic [rtdd_pkg::IDX_W-1:0] r,
                                                    logic [COUNT_WIDTH-1:0] amt);
        table_result_t res;
        logic p_ok, r_ok, progress;
        logic [COUNT_WIDTH-1:0] work [RESOURCES];
        logic finished [PROCESSES];
        res = '0;
        p_ok = p < PROCESSES;
        r_ok = r < RESOURCES;
        case (cmd)
            rtdd_pkg::CMD_SET: begin
                if (r_ok) avail_units[r] = amt;
            end
            rtdd_pkg::CMD_OPEN: begin
                if (p_ok) occupied[p] = 1'b1;
            end
            rtdd_pkg::CMD_REQ: begin
                if (!p_ok || !r_ok) begin
                    res.status = rtdd_pkg::STAT_PENDING;
                end else if (avail_units[r] != 0 && held[p][r] != COUNT_MAX) begin
                    held[p][r]++;
                    avail_units[r]--;
                    waiting_on[p] = rtdd_pkg::NONE_PENDING;
                end else begin
                    waiting_on[p] = r;
                    res.status = rtdd_pkg::STAT_PENDING;
                end
            end
            rtdd_pkg::CMD_REL: begin
                if (p_ok && r_ok && held[p][r] != 0) begin
                    held[p][r]--;
                    avail_units[r] = add_sat(avail_units[r], COUNT_WIDTH'(1));
                end else begin
                    res.status = rtdd_pkg::STAT_NONE;
                end
            end
            rtdd_pkg::CMD_CLEAN: begin
                if (p_ok) begin
                    for (int k = 0; k < RESOURCES; k++) begin
                        avail_units[k] = add_sat(avail_units[k], held[p][k]);
                        held[p][k] = '0;
                    end
                    occupied[p] = 1'b0;
                    waiting_on[p] = rtdd_pkg::NONE_PENDING;
                end
            end
            rtdd_pkg::CMD_DETECT: begin
                for (int k = 0; k < RESOURCES; k++) work[k] = avail_units[k];
                for (int q = 0; q < PROCESSES; q++) finished[q] = 1'b0;
                progress = 1'b1;
                while (progress) begin
                    progress = 1'b0;
                    for (int q = 0; q < PROCESSES; q++) begin
                        if (!finished[q] && (!occupied[q] || waiting_on[q] >= RESOURCES
                                || work[waiting_on[q]] != 0)) begin
                            finished[q] = 1'b1;
                            progress = 1'b1;
                            for (int k = 0; k < RESOURCES; k++)
                                work[k] = add_sat(work[k], held[q][k]);
                        end
                    end
                end
                for (int q = 0; q < PROCESSES; q++) begin
                    if (!finished[q]) begin
                        res.mask[q] = 1'b1;
                        res.count++;
                    end
                end
            end
            default: ;
        endcase
        res.avail = r_ok ? avail_units[r] : '0;
        return res;
    endfunction

    assign pending_results = result_q.size();

    always @(posedge aclk) begin
        table_result_t exp_res;
        if (!aresetn) begin
            for (int k = 0; k < RESOURCES; k++) avail_units[k] = '0;
            for (int q = 0; q < PROCESSES; q++) begin
                occupied[q] = 1'b0;
                waiting_on[q] = rtdd_pkg::NONE_PENDING;
                for (int k = 0; k < RESOURCES; k++) held[q][k] = '0;
            end
            result_q.delete();
            fail_count <= 0;
            deadlock_reports <= 0;
        end else begin
            // Result side first: a new command can be taken on the edge an earlier result is taken
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: result transfer with nothing expected", $time);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_res = result_q.pop_front();
                    if (exp_res.status != m_status || exp_res.count != m_deadlock_count
                            || exp_res.mask != m_deadlock_mask
                            || exp_res.avail != m_available_now) begin
                        $display("%0t: mismatch expected st=%0d cnt=%0d mask=%h av=%0d",
                                 $time, exp_res.status, exp_res.count, exp_res.mask,
                                 exp_res.avail);
                        $display("%0t:          actual   st=%0d cnt=%0d mask=%h av=%0d",
                                 $time, m_status, m_deadlock_count, m_deadlock_mask,
                                 m_available_now);
                        fail_count <= fail_count + 1;
                    end
                    if (exp_res.count != 0) deadlock_reports <= deadlock_reports + 1;
                end
            end
            if (s_valid && s_ready)
                result_q.push_back(apply_command(s_cmd, s_process, s_resource, s_amount));
        end
    end
endmodule

// ===== tb/resource_table_deadlock_detector_tb.sv =====
// Testbench top: stimulus, idling, watchdog and verdict for the deadlock detector.
`timescale 1ns / 1ps
module resource_table_deadlock_detector_tb;
    localparam int PROCESSES   = 18;
    localparam int RESOURCES   = 20;
    localparam int COUNT_WIDTH = 13;
    localparam int STALL_LIMIT = 20000;

    // Command codes the block does not define
    localparam logic [rtdd_pkg::CMD_W-1:0] CMD_RSVD_A = 3'd6;
    localparam logic [rtdd_pkg::CMD_W-1:0] CMD_RSVD_B = 3'd7;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [rtdd_pkg::CMD_W-1:0]     s_cmd = '0;
    logic [rtdd_pkg::IDX_W-1:0]     s_process = '0;
    logic [rtdd_pkg::IDX_W-1:0]     s_resource = '0;
    logic [COUNT_WIDTH-1:0]         s_amount = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [rtdd_pkg::STAT_W-1:0]    m_status;
    logic [$clog2(PROCESSES+1)-1:0] m_deadlock_count;
    logic [PROCESSES-1:0]           m_deadlock_mask;
    logic [COUNT_WIDTH-1:0]         m_available_now;

    int fail_count, pending_results, deadlock_reports;
    int send_idle_pct = 18, recv_idle_pct = 70;
    int commands_sent = 0, idle_cycles = 0;

    always #5 aclk = ~aclk;

    resource_table_deadlock_detector #(
        .PROCESSES(PROCESSES), .RESOURCES(RESOURCES), .COUNT_WIDTH(COUNT_WIDTH)
    ) u_top (.*);

    resource_table_deadlock_detector_checker #(
        .PROCESSES(PROCESSES), .RESOURCES(RESOURCES), .COUNT_WIDTH(COUNT_WIDTH)
    ) u_checker (.*);

    // Receiver stalls at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: cycles with no transfer on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("resource_table_deadlock_detector_tb NOT OK");
            $finish;
        end
    end

    // Offer one command and hold it until transferred
    task automatic send_cmd(logic [rtdd_pkg::CMD_W-1:0] cmd, int p, int r, int amt);
        logic idle;
        idle = ($urandom_range(99) < send_idle_pct);
        if (idle) s_valid <= 1'b0;
        while (idle) begin
            @(posedge aclk);
            idle = ($urandom_range(99) < send_idle_pct);
        end
        s_valid    <= 1'b1;
        s_cmd      <= cmd;
        s_process  <= p[rtdd_pkg::IDX_W-1:0];
        s_resource <= r[rtdd_pkg::IDX_W-1:0];
        s_amount   <= amt[COUNT_WIDTH-1:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        commands_sent++;
    endtask

    // Sender goes quiet until every expected result has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    // Mostly well-formed traffic on a few slots and classes so detect finds cycles
    task automatic random_cmd();
        int pick, p, r;
        pick = $urandom_range(99);
        p = $urandom_range(5);
        r = $urandom_range(3);
        if (pick < 4)
            send_cmd(rtdd_pkg::CMD_SET, $urandom_range(31), $urandom_range(31), $urandom());
        else if (pick < 10)
            send_cmd(rtdd_pkg::CMD_SET, r, r, $urandom_range(3));
        else if (pick < 20)
            send_cmd(rtdd_pkg::CMD_OPEN, p, r, 0);
        else if (pick < 50)
            send_cmd(rtdd_pkg::CMD_REQ, p, r, 0);
        else if (pick < 60)
            send_cmd(rtdd_pkg::CMD_REL, p, r, 0);
        else if (pick < 66)
            send_cmd(rtdd_pkg::CMD_CLEAN, p, r, 0);
        else if (pick < 82)
            send_cmd(rtdd_pkg::CMD_DETECT, p, r, 0);
        else if (pick < 86)
            send_cmd(rtdd_pkg::CMD_W'($urandom_range(7)), $urandom_range(31),
                     $urandom_range(31), $urandom());
        else
            send_cmd(rtdd_pkg::CMD_W'($urandom_range(5)), $urandom_range(PROCESSES-1),
                     $urandom_range(RESOURCES-1), $urandom());
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, every command, out-of-range and reserved-code cases
        send_cmd(rtdd_pkg::CMD_SET, 0, RESOURCES-1, 8191);
        send_cmd(rtdd_pkg::CMD_SET, 0, 0, 1);
        send_cmd(rtdd_pkg::CMD_SET, 0, 31, 5);
        send_cmd(rtdd_pkg::CMD_OPEN, PROCESSES-1, 0, 0);
        send_cmd(rtdd_pkg::CMD_OPEN, 31, 0, 0);
        send_cmd(rtdd_pkg::CMD_OPEN, 0, 0, 0);
        send_cmd(rtdd_pkg::CMD_REQ, 0, 0, 0);
        send_cmd(rtdd_pkg::CMD_REQ, PROCESSES-1, 0, 0);
        send_cmd(rtdd_pkg::CMD_REQ, 0, 31, 0);
        send_cmd(rtdd_pkg::CMD_REQ, 31, 0, 0);
        send_cmd(rtdd_pkg::CMD_REQ, 3, RESOURCES-1, 0);
        send_cmd(rtdd_pkg::CMD_DETECT, 0, 0, 0);
        send_cmd(rtdd_pkg::CMD_REL, 5, 5, 0);
        send_cmd(rtdd_pkg::CMD_REL, 31, 31, 0);
        send_cmd(rtdd_pkg::CMD_REL, 3, RESOURCES-1, 0);
        send_cmd(rtdd_pkg::CMD_REQ, 0, 1, 0);
        send_cmd(rtdd_pkg::CMD_DETECT, 0, 0, 0);
        send_cmd(rtdd_pkg::CMD_CLEAN, 0, 0, 0);
        send_cmd(rtdd_pkg::CMD_CLEAN, 31, 0, 0);
        send_cmd(CMD_RSVD_A, 31, 31, 8191);
        send_cmd(CMD_RSVD_B, 0, 0, 0);
        send_cmd(rtdd_pkg::CMD_CLEAN, 3, RESOURCES-1, 0);
        send_cmd(rtdd_pkg::CMD_DETECT, 31, 31, 8191);

        // Hold off until the table has answered everything
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 70 : 0;
            recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 18 : 0;
            for (int i = 0; i < 430; i++) random_cmd();
        end

        drain();
        repeat (50) @(posedge aclk);
        $display("Sent %0d commands over three idling phases; %0d detects found deadlock.",
                 commands_sent, deadlock_reports);
        if (fail_count == 0)
            $display("resource_table_deadlock_detector_tb OK");
        else
            $display("resource_table_deadlock_detector_tb NOT OK");
        $finish;
    end
endmodule
